>>> sv/abrf_pkg.sv
`default_nettype none

package abrf_pkg;

  // slot index into the banked store
  localparam int unsigned SlotCount = 36;
  localparam int unsigned SlotW     = 6;

  // operation codes
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // logical register numbers with special meaning
  localparam logic [4:0] IDX_R7   = 5'd7;
  localparam logic [4:0] IDX_R12  = 5'd12;
  localparam logic [4:0] IDX_R13  = 5'd13;
  localparam logic [4:0] IDX_R14  = 5'd14;
  localparam logic [4:0] IDX_PC   = 5'd15;
  localparam logic [4:0] IDX_CPSR = 5'd16;
  localparam logic [4:0] IDX_SPSR = 5'd17;

  // processor mode codes
  localparam logic [4:0] MODE_USR = 5'b10000;
  localparam logic [4:0] MODE_FIQ = 5'b10001;
  localparam logic [4:0] MODE_IRQ = 5'b10010;
  localparam logic [4:0] MODE_SVC = 5'b10011;
  localparam logic [4:0] MODE_ABT = 5'b10111;
  localparam logic [4:0] MODE_UND = 5'b11011;
  localparam logic [4:0] MODE_SYS = 5'b11111;

  // exception bank numbers
  localparam logic [2:0] BANK_SVC = 3'd0;
  localparam logic [2:0] BANK_ABT = 3'd1;
  localparam logic [2:0] BANK_UND = 3'd2;
  localparam logic [2:0] BANK_IRQ = 3'd3;
  localparam logic [2:0] BANK_FIQ = 3'd4;

  // physical slot layout
  localparam logic [SlotW-1:0] SLOT_FIQ_R8   = 6'd13;
  localparam logic [SlotW-1:0] SLOT_USR_R13  = 6'd18;
  localparam logic [SlotW-1:0] SLOT_USR_R14  = 6'd19;
  localparam logic [SlotW-1:0] SLOT_BANK_R13 = 6'd20;
  localparam logic [SlotW-1:0] SLOT_BANK_R14 = 6'd25;
  localparam logic [SlotW-1:0] SLOT_PC       = 6'd30;
  localparam logic [SlotW-1:0] SLOT_SPSR     = 6'd31;

  // what an access targets
  typedef enum logic [1:0] {
    TGT_BANK,
    TGT_CPSR,
    TGT_NONE
  } target_e;

  typedef struct packed {
    target_e          target;
    logic [SlotW-1:0] slot;
    logic             privileged;
    logic             has_spsr;
  } map_t;

  typedef struct packed {
    logic        opcode;
    logic [4:0]  reg_index;
    logic [31:0] write_value;
  } in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        access_error;
    logic        privileged;
    logic        has_spsr;
  } out_t;

endpackage

`default_nettype wire

>>> sv/abrf_map.sv
`default_nettype none

module abrf_map import abrf_pkg::*; (
  input  logic [4:0] reg_index_i,
  input  logic [4:0] mode_i,
  output map_t       map_o
);

  logic             bank_ok;
  logic [2:0]       bank;
  logic [SlotW-1:0] idx_ext;

  assign idx_ext = {1'b0, reg_index_i};

  // exception bank of the current mode
  always_comb begin
    bank_ok = 1'b1;
    bank    = BANK_SVC;
    unique case (mode_i)
      MODE_SVC: bank = BANK_SVC;
      MODE_ABT: bank = BANK_ABT;
      MODE_UND: bank = BANK_UND;
      MODE_IRQ: bank = BANK_IRQ;
      MODE_FIQ: bank = BANK_FIQ;
      default:  bank_ok = 1'b0;
    endcase
  end

  // logical register to physical slot
  always_comb begin
    map_o.target     = TGT_BANK;
    map_o.slot       = idx_ext;
    map_o.privileged = (mode_i != MODE_USR);
    map_o.has_spsr   = (mode_i != MODE_USR) && (mode_i != MODE_SYS);
    if (reg_index_i <= IDX_R7) begin
      map_o.slot = idx_ext;
    end else if (reg_index_i <= IDX_R12) begin
      map_o.slot = (mode_i == MODE_FIQ) ? idx_ext + (SLOT_FIQ_R8 - 6'd8) : idx_ext;
    end else if (reg_index_i == IDX_R13) begin
      map_o.slot = bank_ok ? SLOT_BANK_R13 + {3'b000, bank} : SLOT_USR_R13;
    end else if (reg_index_i == IDX_R14) begin
      map_o.slot = bank_ok ? SLOT_BANK_R14 + {3'b000, bank} : SLOT_USR_R14;
    end else if (reg_index_i == IDX_PC) begin
      map_o.slot = SLOT_PC;
    end else if (reg_index_i == IDX_CPSR) begin
      map_o.target = TGT_CPSR;
    end else if (reg_index_i == IDX_SPSR && bank_ok) begin
      map_o.slot = SLOT_SPSR + {3'b000, bank};
    end else begin
      map_o.target = TGT_NONE;
    end
  end

endmodule

`default_nettype wire

>>> sv/arm_banked_register_file_top.sv
// Banked register file, 36 banked words plus CPSR, seen as R0-R14, PC,
// CPSR and SPSR through the processor mode held in CPSR bits 4:0.
// Input channel (in_valid_i/in_ready_o/in_data_i): one beat is one read or
// write of a logical register. Output channel (out_valid_o/out_ready_i/
// out_data_o): one result beat per input beat, in order.
// The result of a beat is registered and shows in the cycle after the beat is
// accepted. Throughput is one beat per cycle while the receiver takes results,
// set by the single write and single registered read port of the banked store;
// a CPSR write changes the mode seen by the very next beat.
// The mode flags in a result describe the mode before that access.
// When the receiver stalls, the result register holds and the input side
// stops taking beats until the result is taken.
// Reset clears CPSR and the output valid; the banked words stay undefined
// until written and need no clearing pass.
`default_nettype none

module arm_banked_register_file_top import abrf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic        in_fire;
  map_t        map;
  logic [31:0] cpsr_q;
  logic [31:0] mem_q [SlotCount];
  logic [31:0] rd_mem_q;
  logic [31:0] rd_other_q;
  logic        sel_mem_q;
  logic        out_valid_q;
  logic        err_q;
  logic        priv_q;
  logic        spsr_q;
  logic        is_write;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_write   = (in_data_i.opcode == OP_WRITE);

  // register number to slot decode
  abrf_map u_map (
    .reg_index_i (in_data_i.reg_index),
    .mode_i      (cpsr_q[4:0]),
    .map_o       (map)
  );

  // banked store: one write and one registered read per beat
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_mem_q <= mem_q[map.slot];
      if (is_write && map.target == TGT_BANK) begin
        mem_q[map.slot] <= in_data_i.write_value;
      end
    end
  end

  // status word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpsr_q <= '0;
    end else if (in_fire && is_write && map.target == TGT_CPSR) begin
      cpsr_q <= in_data_i.write_value;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sel_mem_q  <= !is_write && (map.target == TGT_BANK);
      rd_other_q <= (!is_write && map.target == TGT_CPSR) ? cpsr_q : 32'd0;
      err_q      <= (map.target == TGT_NONE);
      priv_q     <= map.privileged;
      spsr_q     <= map.has_spsr;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign out_data_o.read_data    = sel_mem_q ? rd_mem_q : rd_other_q;
  assign out_data_o.access_error = err_q;
  assign out_data_o.privileged   = priv_q;
  assign out_data_o.has_spsr     = spsr_q;

  // an accepted beat always leaves a result behind
  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_o)
    else $error("accepted beat produced no result");

  // a CPSR write lands before the next beat is decoded
  a_cpsr_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_write && in_data_i.reg_index == IDX_CPSR)
      |=> cpsr_q == $past(in_data_i.write_value))
    else $error("CPSR write lost");

  // flagged accesses return zero data
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.access_error) |-> out_data_o.read_data == 32'd0)
    else $error("error result carries data");

  // has_spsr implies privileged
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.has_spsr) |-> out_data_o.privileged)
    else $error("mode flags inconsistent");

endmodule

`default_nettype wire
